// ===== hdl/hts_pkg.sv =====
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types and character constants for the HTML tag strip / entity decode.
// ----------------------------------------------------------------------------
`default_nettype none

package hts_pkg;

    typedef logic [7:0] t_byte;

    localparam int ENT_NUM  = 6;   // number of named entities
    localparam int HOLD_MAX = 5;   // held bytes, leading '&' included
    localparam int OUT_MAX  = 7;   // most results one item can cause

    typedef logic [ENT_NUM-1:0]            t_cand;
    typedef logic [$clog2(HOLD_MAX+1)-1:0] t_hlen;
    typedef logic [$clog2(OUT_MAX+1)-1:0]  t_ocnt;

    localparam t_byte CH_AMP   = 8'h26;
    localparam t_byte CH_LT    = 8'h3C;
    localparam t_byte CH_GT    = 8'h3E;
    localparam t_byte CH_SEMI  = 8'h3B;
    localparam t_byte CH_LF    = 8'h0A;
    localparam t_byte CH_CR    = 8'h0D;
    localparam t_byte CH_TAB   = 8'h09;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_NUL   = 8'h00;

    // name letters after the '&', zero padded
    localparam t_byte ENT_NAME [ENT_NUM][HOLD_MAX] = '{
        '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},   // amp;
        '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},   // lt;
        '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},   // gt;
        '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},   // quot;
        '{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},   // apos;
        '{8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B}    // nbsp;
    };

    localparam t_byte ENT_VAL [ENT_NUM] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h20};

endpackage

`default_nettype wire

// ===== hdl/html_tag_strip_entity_decode.sv =====
// ----------------------------------------------------------------------------
// html_tag_strip_entity_decode
// Drops HTML tags, decodes six named entities and folds whitespace, one
// source byte per item; results leave through a small result buffer.
// ----------------------------------------------------------------------------
// Output: the first result of an item is registered and is on the output in the cycle after accept.
// Throughput: one item per cycle while each item yields at most one result
// and the output is ready; an item with more results holds the input until its
// last result is taken, since the result buffer drains one entry per ready cycle through the single output port.
// Reset: synchronous, active low; clears tag, entity and spacing state and
// empties the result buffer.
`default_nettype none

module html_tag_strip_entity_decode (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  wire logic        i_s_tlast,   // final_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] out_byte
    output logic             o_m_tuser,   // is_terminator
    output logic             o_m_tlast    // run_last
);
    import hts_pkg::*;

    // persistent state
    logic  r_inside_tag;
    t_hlen r_pend_len;
    t_byte r_pend [HOLD_MAX];
    t_cand r_cand;
    logic  r_emitted_any;
    logic  r_last_space;

    // result buffer
    t_byte r_buf_b [OUT_MAX];
    logic  r_buf_t [OUT_MAX];
    t_ocnt r_rem;
    t_ocnt r_idx;

    // next values
    logic  n_inside_tag;
    t_hlen n_pend_len;
    t_byte n_pend [HOLD_MAX];
    t_cand n_cand;
    logic  n_emitted_any;
    logic  n_last_space;
    t_byte n_buf_b [OUT_MAX];
    logic  n_buf_t [OUT_MAX];
    t_ocnt n_cnt;

    logic  in_fire;
    logic  out_fire;

    assign o_m_tvalid = (r_rem != '0);
    assign out_fire   = o_m_tvalid && i_m_tready;
    assign o_s_tready = (r_rem == '0) || ((r_rem == t_ocnt'(1)) && i_m_tready);
    assign in_fire    = i_s_tvalid && o_s_tready;

    assign o_m_tdata = o_m_tvalid ? r_buf_b[r_idx] : CH_NUL;
    assign o_m_tuser = o_m_tvalid ? r_buf_t[r_idx] : 1'b0;
    assign o_m_tlast = (r_rem == t_ocnt'(1));

    always_comb begin
        t_byte c;
        t_cand alive;
        t_hlen pos;
        logic  do_plain;
        t_byte ent_b;

        c             = i_s_tdata;
        alive         = '0;
        do_plain      = 1'b0;
        ent_b         = CH_NUL;
        n_inside_tag  = r_inside_tag;
        n_pend_len    = r_pend_len;
        n_pend        = r_pend;
        n_cand        = r_cand;
        n_emitted_any = r_emitted_any;
        n_last_space  = r_last_space;
        n_cnt         = '0;
        for (int i = 0; i < OUT_MAX; i++) begin
            n_buf_b[i] = CH_NUL;
            n_buf_t[i] = 1'b0;
        end

        pos = r_pend_len - t_hlen'(1);
        if (r_pend_len != '0 && pos < t_hlen'(HOLD_MAX)) begin
            for (int k = 0; k < ENT_NUM; k++) begin
                alive[k] = r_cand[k] && (ENT_NAME[k][pos] == c);
            end
        end
        for (int k = ENT_NUM - 1; k >= 0; k--) begin
            if (alive[k]) ent_b = ENT_VAL[k];
        end

        if (r_pend_len == '0) begin
            do_plain = 1'b1;
        end else if (alive != '0 && c == CH_SEMI) begin
            n_buf_b[n_cnt[2:0]] = ent_b;
            n_cnt               = n_cnt + t_ocnt'(1);
            n_emitted_any       = 1'b1;
            n_last_space        = (ent_b == CH_SPACE);
            n_pend_len          = '0;
            n_cand              = '0;
        end else if (alive != '0 && r_pend_len < t_hlen'(HOLD_MAX)) begin
            n_pend[r_pend_len] = c;
            n_pend_len         = r_pend_len + t_hlen'(1);
            n_cand             = alive;
        end else begin
            // mismatch: '&' and held letters go out as text
            for (int i = 0; i < HOLD_MAX; i++) begin
                if (t_hlen'(i) < r_pend_len) begin
                    n_buf_b[n_cnt[2:0]] = r_pend[i];
                    n_cnt               = n_cnt + t_ocnt'(1);
                    n_emitted_any       = 1'b1;
                    n_last_space        = (r_pend[i] == CH_SPACE);
                end
            end
            n_pend_len = '0;
            n_cand     = '0;
            do_plain   = 1'b1;
        end

        if (do_plain) begin
            if (c == CH_LT) begin
                n_inside_tag = 1'b1;
            end else if (c == CH_GT) begin
                n_inside_tag = 1'b0;
            end else if (n_inside_tag) begin
                n_inside_tag = 1'b1;
            end else if (c == CH_AMP) begin
                n_pend[0]  = c;
                n_pend_len = t_hlen'(1);
                n_cand     = '1;
            end else if (c == CH_LF || c == CH_CR || c == CH_TAB) begin
                if (n_emitted_any && !n_last_space) begin
                    n_buf_b[n_cnt[2:0]] = CH_SPACE;
                    n_cnt               = n_cnt + t_ocnt'(1);
                    n_last_space        = 1'b1;
                end
            end else begin
                n_buf_b[n_cnt[2:0]] = c;
                n_cnt               = n_cnt + t_ocnt'(1);
                n_emitted_any       = 1'b1;
                n_last_space        = (c == CH_SPACE);
            end
        end

        if (i_s_tlast) begin
            for (int i = 0; i < HOLD_MAX; i++) begin
                if (t_hlen'(i) < n_pend_len) begin
                    n_buf_b[n_cnt[2:0]] = n_pend[i];
                    n_cnt               = n_cnt + t_ocnt'(1);
                end
            end
            n_buf_b[n_cnt[2:0]] = CH_NUL;
            n_buf_t[n_cnt[2:0]] = 1'b1;
            n_cnt               = n_cnt + t_ocnt'(1);
            n_inside_tag        = 1'b0;
            n_pend_len          = '0;
            n_cand              = '0;
            n_emitted_any       = 1'b0;
            n_last_space        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside_tag  <= 1'b0;
            r_pend_len    <= '0;
            r_cand        <= '0;
            r_emitted_any <= 1'b0;
            r_last_space  <= 1'b0;
            r_rem         <= '0;
            r_idx         <= '0;
        end else if (in_fire) begin
            r_inside_tag  <= n_inside_tag;
            r_pend_len    <= n_pend_len;
            r_cand        <= n_cand;
            r_emitted_any <= n_emitted_any;
            r_last_space  <= n_last_space;
            r_rem         <= n_cnt;
            r_idx         <= '0;
        end else if (out_fire) begin
            r_rem <= r_rem - t_ocnt'(1);
            r_idx <= r_idx + t_ocnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_pend  <= n_pend;
            r_buf_b <= n_buf_b;
            r_buf_t <= n_buf_t;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem > t_ocnt'(1)) |-> !o_s_tready)
        else $error("input accepted while results still queued");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_s_tlast) |=> (r_pend_len == '0 && !r_inside_tag && !r_emitted_any))
        else $error("state not cleared after final item");

    a_term_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("terminator not on last result");

    a_hold_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_len <= t_hlen'(HOLD_MAX))
        else $error("held entity prefix too long");

    a_cand_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_len == '0) == (r_cand == '0))
        else $error("entity candidates out of step with held prefix");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of html_tag_strip_entity_decode: short directed strings,
// then random HTML-like text under input/output idling and a long output
// hold-off. Each accepted item is run through a local predictor of the
// cleaner; every result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hts_pkg::*;

    localparam int STALL_LIMIT = 2000;   // cycles with no item accepted and no result taken
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        t_byte ch;
        logic  term;
        logic  run_last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;   // [7:0] text_byte
    logic        i_s_tlast = 1'b0;    // final_byte
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;           // [7:0] out_byte
    logic        o_m_tuser;           // is_terminator
    logic        o_m_tlast;           // run_last

    html_tag_strip_entity_decode dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    int      tx_idle_pct  = 0;
    int      rx_idle_pct  = 0;
    int      rx_hold_left = 0;
    int      sent_count   = 0;
    int      fail_count   = 0;
    int      quiet_cycles = 0;
    t_result clean_q[$];     // cleaned bytes still to come out
    t_result step_q[$];

    // predictor state
    bit      p_in_tag;
    int      p_hold_len;
    t_byte   p_hold [HOLD_MAX];
    t_cand   p_cand;
    bit      p_sent_any;
    bit      p_prev_space;

    function automatic string ent_text(int k);
        case (k)
            0: return "amp;";
            1: return "lt;";
            2: return "gt;";
            3: return "quot;";
            4: return "apos;";
            default: return "nbsp;";
        endcase
    endfunction

    function automatic t_byte ent_char(int k);
        case (k)
            0: return CH_AMP;
            1: return CH_LT;
            2: return CH_GT;
            3: return 8'h22;
            4: return 8'h27;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic void clear_state();
        p_in_tag     = 1'b0;
        p_hold_len   = 0;
        p_cand       = '0;
        p_sent_any   = 1'b0;
        p_prev_space = 1'b0;
    endfunction

    function automatic void push_out(t_byte b, bit term);
        step_q.push_back('{ch: b, term: term, run_last: 1'b0});
        if (!term) begin
            p_sent_any   = 1'b1;
            p_prev_space = (b == CH_SPACE);
        end
    endfunction

    function automatic void flush_hold();
        for (int i = 0; i < p_hold_len; i++)
            push_out(p_hold[i], 1'b0);
        p_hold_len = 0;
        p_cand     = '0;
    endfunction

    function automatic void plain_byte(t_byte c);
        if (c == CH_LT) begin
            p_in_tag = 1'b1;
        end else if (c == CH_GT) begin
            p_in_tag = 1'b0;
        end else if (p_in_tag) begin
            // dropped inside a tag
        end else if (c == CH_AMP) begin
            p_hold[0]  = c;
            p_hold_len = 1;
            p_cand     = '1;
        end else if (c == CH_LF || c == CH_CR || c == CH_TAB) begin
            if (p_sent_any && !p_prev_space)
                push_out(CH_SPACE, 1'b0);
        end else begin
            push_out(c, 1'b0);
        end
    endfunction

    function automatic void take_byte(t_byte c);
        t_cand alive;
        int    pos;
        int    hit;
        string nm;
        alive = '0;
        if (p_hold_len == 0) begin
            plain_byte(c);
            return;
        end
        pos = p_hold_len - 1;
        for (int k = 0; k < ENT_NUM; k++) begin
            nm = ent_text(k);
            if (p_cand[k] && pos < nm.len() && t_byte'(nm[pos]) == c)
                alive[k] = 1'b1;
        end
        if (alive != '0 && c == CH_SEMI) begin
            hit = 0;
            while (!alive[hit])
                hit++;
            push_out(ent_char(hit), 1'b0);
            p_hold_len = 0;
            p_cand     = '0;
        end else if (alive != '0 && p_hold_len < HOLD_MAX) begin
            p_hold[p_hold_len] = c;
            p_hold_len++;
            p_cand = alive;
        end else begin
            // mismatch: '&' and held letters go out literally first
            flush_hold();
            plain_byte(c);
        end
    endfunction

    function automatic void predict_clean(t_byte c, bit fin);
        step_q.delete();
        take_byte(c);
        if (fin) begin
            flush_hold();
            push_out(CH_NUL, 1'b1);
            clear_state();
        end
        if (step_q.size() > 0)
            step_q[step_q.size()-1].run_last = 1'b1;
        foreach (step_q[i])
            clean_q.push_back(step_q[i]);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // caller sits at a falling edge; returns at the falling edge after accept
    task automatic send_item(t_byte b, bit fin);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid = 1'b0;
            i_s_tdata  = t_byte'($urandom);
            i_s_tlast  = 1'($urandom);
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = b;
        i_s_tlast  = fin;
        do @(posedge i_clk); while (!o_s_tready);
        predict_clean(b, fin);
        sent_count++;
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic send_str(string s, bit fin);
        for (int i = 0; i < s.len(); i++)
            send_item(t_byte'(s[i]), fin && (i == s.len() - 1));
    endtask

    task automatic add_fragment(ref t_byte txt[$]);
        int    kind;
        int    n;
        int    k;
        string nm;
        t_byte b;
        kind = $urandom_range(99);
        k    = $urandom_range(ENT_NUM - 1);
        nm   = ent_text(k);
        if (kind < 25) begin
            n = $urandom_range(1, 6);
            repeat (n) txt.push_back(t_byte'($urandom_range(8'h61, 8'h7A)));
        end else if (kind < 40) begin
            txt.push_back(CH_LT);
            n = $urandom_range(0, 5);
            repeat (n) begin
                b = t_byte'($urandom_range(1, 255));
                txt.push_back(b == CH_GT ? 8'h61 : b);
            end
            txt.push_back(CH_GT);
        end else if (kind < 65) begin
            txt.push_back(CH_AMP);
            for (int i = 0; i < nm.len(); i++)
                txt.push_back(t_byte'(nm[i]));
        end else if (kind < 78) begin
            // broken entity: a true prefix, then any byte
            txt.push_back(CH_AMP);
            n = $urandom_range(0, nm.len() - 2);
            for (int i = 0; i < n; i++)
                txt.push_back(t_byte'(nm[i]));
            txt.push_back(t_byte'($urandom_range(1, 255)));
        end else if (kind < 90) begin
            case ($urandom_range(3))
                0: txt.push_back(CH_LF);
                1: txt.push_back(CH_CR);
                2: txt.push_back(CH_TAB);
                default: txt.push_back(CH_SPACE);
            endcase
        end else begin
            txt.push_back(t_byte'($urandom_range(1, 255)));
        end
    endtask

    task automatic send_random_string();
        t_byte txt[$];
        int    frags;
        bit    fin;
        frags = $urandom_range(1, 12);
        repeat (frags) add_fragment(txt);
        fin = ($urandom_range(99) < 85);
        foreach (txt[i])
            send_item(txt[i], fin && (i == txt.size() - 1));
    endtask

    task automatic test_entity_decode();
        send_item(CH_TAB, 1'b0);     // whitespace before any output is dropped
        send_str("A&amp;", 1'b0);
        send_str("&nbsp;", 1'b0);    // longest hold
    endtask

    task automatic test_whitespace_fold();
        send_item(CH_LF, 1'b0);      // last byte out was a space
        send_item(CH_CR, 1'b0);
    endtask

    task automatic test_tag_drop();
        send_str("&q<", 1'b0);       // bracket breaks the pending entity
        send_str("x>", 1'b0);
    endtask

    task automatic test_byte_extremes();
        send_item(CH_NUL, 1'b0);
        send_item(8'hFF, 1'b0);
    endtask

    task automatic test_final_flush();
        send_str("&ap", 1'b1);       // final in the middle of an entity
        send_str("<a", 1'b1);        // final inside a tag
    endtask

    task automatic test_random_text(int n_items);
        int start;
        start = sent_count;
        while (sent_count - start < n_items)
            send_random_string();
    endtask

    task automatic test_backpressure();
        @(posedge i_clk);
        rx_hold_left = 200;
        @(negedge i_clk);
        test_random_text(40);
    endtask

    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_tready = 1'b0;
        end else begin
            i_m_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (clean_q.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata, 0);
            end else begin
                want = clean_q.pop_front();
                if (o_m_tdata !== want.ch)
                    report_mismatch("out_byte", o_m_tdata, want.ch);
                if (o_m_tuser !== want.term)
                    report_mismatch("is_terminator", o_m_tuser, want.term);
                if (o_m_tlast !== want.run_last)
                    report_mismatch("run_last", o_m_tlast, want.run_last);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        clear_state();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_entity_decode();
        test_whitespace_fold();
        test_tag_drop();
        test_byte_extremes();
        test_final_flush();

        tx_idle_pct = 12;
        rx_idle_pct = 78;
        test_random_text(130);
        tx_idle_pct = 78;
        rx_idle_pct = 12;
        test_random_text(130);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_backpressure();
        test_random_text(130);

        i_s_tvalid = 1'b0;
        while (clean_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (clean_q.size() != 0)
            report_mismatch("results left over", clean_q.size(), 0);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
